// ===== src/imht_pkg.sv =====
// Package for the image-map hit test block.
// Holds the sizing constants, command codes, shape codes and the sequencer state type;
// no dependencies.
package imht_pkg;

    // Table and coordinate sizes, fixed by the port widths.
    localparam int MAX_AREAS    = 64;
    localparam int MAX_VERTICES = 256;
    localparam int COORD_WIDTH  = 16;

    typedef enum logic [1:0] {
        MODE_WR_AREA   = 2'd0,
        MODE_WR_VERTEX = 2'd1,
        MODE_QUERY     = 2'd2,
        MODE_NONE      = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SHAPE_BAD    = 2'd0,
        SHAPE_RECT   = 2'd1,
        SHAPE_CIRCLE = 2'd2,
        SHAPE_POLY   = 2'd3
    } t_shape;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AREA_RD,
        ST_AREA_DEC,
        ST_V0_RD,
        ST_V1_RD,
        ST_V1_WAIT,
        ST_EVAL,
        ST_CIRC_MUL,
        ST_CIRC_SUM,
        ST_POLY_RD,
        ST_POLY_EDGE,
        ST_POLY_MUL,
        ST_POLY_CMP,
        ST_NEXT,
        ST_DONE
    } t_state;

endpackage

// ===== src/image_map_hit_test_top.sv =====
// Top level of the image-map hit test block.
// Depends on imht_pkg; holds the area table, the vertex store and the query sequencer.

// Commands are taken while busy is low. Area and vertex writes give no result.
// A query walks areas 0 .. area_count-1, capped at MAX_AREAS, in order through
// the area table and vertex store, both single-port memories with a registered
// read. Before every polygon edge after the first, the far vertex is read and
// loaded; an edge that needs the cross-multiply goes on through ST_POLY_MUL and
// ST_POLY_CMP. The walk stops at the first hit; busy stays high through ST_DONE.
// The result appears on o_hit and o_area_index in the cycle after ST_DONE, for
// exactly one cycle with o_valid high; the receiver cannot stall it.
module image_map_hit_test_top
    import imht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_slot,
    input  logic [1:0]  i_shape_code,
    input  logic [7:0]  i_first_vertex,
    input  logic [7:0]  i_vertex_count,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    output logic        o_valid,
    output logic        o_hit,
    output logic [5:0]  o_area_index
);

    localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int CNTW = $clog2(MAX_AREAS + 1);

    // Memories.
    logic [17:0]       r_area_mem [MAX_AREAS];
    logic [2*CW-1:0]   r_vtx_mem  [MAX_VERTICES];
    logic [17:0]       r_area_q;
    logic [2*CW-1:0]   r_vtx_q;

    t_state r_state, n_state;
    logic [6:0]        r_area_count;
    logic [CNTW-1:0]   r_limit;
    logic [CNTW-1:0]   r_ai;
    logic signed [CW-1:0] r_qx, r_qy;
    t_shape            r_shape;
    logic [7:0]        r_first, r_cnt, r_k;
    logic signed [CW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [PW-1:0] r_p1, r_p2, r_p3;
    logic              r_cross, r_found, r_dir_up;
    logic              r_hit_out, r_valid;
    logic [5:0]        r_idx_out;

    logic              rd_area, rd_vtx;
    logic [AW-1:0]     area_addr;
    logic [VW-1:0]     vtx_addr;
    logic [7:0]        vsel;
    logic              accept;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_count <= '0;
        end else if (i_cfg_we) begin
            r_area_count <= i_cfg_wdata;
        end
    end

    // Vertex index selection for the current read. Between polygon edges the
    // read fetches the far end of the next edge, wrapping to the first vertex.
    always_comb begin
        vsel = 8'd0;
        unique case (r_state)
            ST_V1_RD:   vsel = 8'd1;
            ST_POLY_RD: vsel = ((r_k + 8'd2) == r_cnt) ? 8'd0 : (r_k + 8'd2);
            default:    vsel = 8'd0;
        endcase
    end

    assign area_addr = r_ai[AW-1:0];
    assign vtx_addr  = VW'(({24'd0, r_first} + {24'd0, vsel}) % MAX_VERTICES);
    assign rd_area   = (r_state == ST_AREA_RD);
    assign rd_vtx    = (r_state == ST_V0_RD) || (r_state == ST_V1_RD)
                    || (r_state == ST_POLY_RD);

    // Area table port.
    always_ff @(posedge i_clk) begin
        if (accept && i_mode == MODE_WR_AREA && {24'd0, i_slot} < MAX_AREAS) begin
            r_area_mem[i_slot[AW-1:0]] <= {i_shape_code, i_first_vertex, i_vertex_count};
        end else if (rd_area) begin
            r_area_q <= r_area_mem[area_addr];
        end
    end

    // Vertex store port.
    always_ff @(posedge i_clk) begin
        if (accept && i_mode == MODE_WR_VERTEX && {24'd0, i_slot} < MAX_VERTICES) begin
            r_vtx_mem[i_slot[VW-1:0]] <= {i_coord_x[CW-1:0], i_coord_y[CW-1:0]};
        end else if (rd_vtx) begin
            r_vtx_q <= r_vtx_mem[vtx_addr];
        end
    end

    // Edge and shape evaluation helpers.
    logic signed [CW-1:0] vx, vy;
    logic signed [DW-1:0] dx1, dx2, dy1, dy2, dqy;
    logic spans, left_both, right_both, horiz_on, rect_in, edge_cross;
    assign vx = r_vtx_q[2*CW-1:CW];
    assign vy = r_vtx_q[CW-1:0];

    assign spans = ((r_y1 <= r_qy) && (r_y2 > r_qy)) || ((r_y1 > r_qy) && (r_y2 <= r_qy));
    assign left_both  = (r_qx >= r_x1) && (r_qx >= r_x2);
    assign right_both = (r_qx < r_x1) && (r_qx < r_x2);
    assign horiz_on = (r_y1 == r_y2) && (r_qy == r_y1)
        && (((r_qx >= r_x1) && (r_qx <= r_x2)) || ((r_qx <= r_x1) && (r_qx >= r_x2)));
    assign rect_in = (((r_qx >= r_x1) && (r_qx <= r_x2)) || ((r_qx <= r_x1) && (r_qx >= r_x2)))
        && (((r_qy >= r_y1) && (r_qy <= r_y2)) || ((r_qy <= r_y1) && (r_qy >= r_y2)));
    assign dx1 = DW'(r_qx) - DW'(r_x1);
    assign dy1 = DW'(r_y2) - DW'(r_y1);
    assign dx2 = DW'(r_x2) - DW'(r_x1);
    assign dqy = DW'(r_qy) - DW'(r_y1);
    assign dy2 = DW'(r_qy) - DW'(r_y1);
    assign edge_cross = r_dir_up ? (r_p1 >= r_p2) : (r_p1 <= r_p2);

    // Next state. Between polygon edges ST_V1_WAIT loads the far vertex.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (accept && i_mode == MODE_QUERY) n_state = ST_NEXT;
            ST_AREA_RD:   n_state = ST_AREA_DEC;
            ST_AREA_DEC: begin
                if (t_shape'(r_area_q[17:16]) == SHAPE_BAD) n_state = ST_NEXT;
                else if (t_shape'(r_area_q[17:16]) == SHAPE_POLY && r_area_q[7:0] == 8'd0)
                    n_state = ST_NEXT;
                else n_state = ST_V0_RD;
            end
            ST_V0_RD:     n_state = ST_V1_RD;
            ST_V1_RD:     n_state = ST_V1_WAIT;
            ST_V1_WAIT:   n_state = (r_shape == SHAPE_POLY) ? ST_POLY_EDGE : ST_EVAL;
            ST_EVAL:      n_state = (r_shape == SHAPE_CIRCLE) ? ST_CIRC_MUL : ST_NEXT;
            ST_CIRC_MUL:  n_state = ST_CIRC_SUM;
            ST_CIRC_SUM:  n_state = ST_NEXT;
            ST_POLY_RD:   n_state = ST_V1_WAIT;
            ST_POLY_EDGE: begin
                priority if (horiz_on) n_state = ST_NEXT;
                else if (spans && !left_both && !right_both) n_state = ST_POLY_MUL;
                else if ((r_k + 8'd1) == r_cnt) n_state = ST_NEXT;
                else n_state = ST_POLY_RD;
            end
            ST_POLY_MUL:  n_state = ST_POLY_CMP;
            ST_POLY_CMP:  n_state = ((r_k + 8'd1) == r_cnt) ? ST_NEXT : ST_POLY_RD;
            ST_NEXT:      n_state = (r_found || r_ai == r_limit) ? ST_DONE : ST_AREA_RD;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_qx    <= i_coord_x[CW-1:0];
                r_qy    <= i_coord_y[CW-1:0];
                r_ai    <= '0;
                r_found <= 1'b0;
                r_limit <= ({25'd0, r_area_count} > MAX_AREAS) ? CNTW'(MAX_AREAS)
                                                               : CNTW'(r_area_count);
            end
            ST_AREA_DEC: begin
                r_shape <= t_shape'(r_area_q[17:16]);
                r_first <= r_area_q[15:8];
                r_cnt   <= r_area_q[7:0];
                r_k     <= 8'd0;
                r_cross <= 1'b0;
                r_ai    <= r_ai + 1'b1;
            end
            ST_V1_RD: begin
                r_x1 <= vx;
                r_y1 <= vy;
            end
            ST_V1_WAIT: begin
                if (r_shape == SHAPE_POLY && r_cnt == 8'd1) begin
                    r_x2 <= r_x1;
                    r_y2 <= r_y1;
                end else begin
                    r_x2 <= vx;
                    r_y2 <= vy;
                end
            end
            ST_EVAL: begin
                if (r_shape == SHAPE_RECT) r_found <= rect_in;
                r_p1 <= PW'(dx1) * PW'(dx1);
                r_p2 <= PW'(dqy) * PW'(dqy);
                r_p3 <= PW'(r_x2) * PW'(r_x2);
            end
            ST_CIRC_MUL: begin
                r_p1 <= r_p1 + r_p2;
            end
            ST_CIRC_SUM: begin
                r_found <= !r_x2[CW-1] && (r_p1 <= r_p3);
            end
            ST_POLY_RD: begin
                r_x1 <= r_x2;
                r_y1 <= r_y2;
                r_k  <= r_k + 8'd1;
            end
            ST_POLY_EDGE: begin
                if (horiz_on) r_found <= 1'b1;
                else if (spans && left_both) r_cross <= ~r_cross;
                r_dir_up <= r_y2 > r_y1;
                r_p1 <= PW'(dx1) * PW'(dy1);
                r_p2 <= PW'(dx2) * PW'(dy2);
                if ((r_k + 8'd1) == r_cnt && !horiz_on && !(spans && !left_both && !right_both))
                    r_found <= r_cross ^ (spans && left_both);
            end
            ST_POLY_MUL: begin
            end
            ST_POLY_CMP: begin
                if ((r_k + 8'd1) == r_cnt) r_found <= r_cross ^ edge_cross;
                else if (edge_cross) r_cross <= ~r_cross;
            end
            default: begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_DONE);
        end
        if (r_state == ST_DONE) begin
            r_hit_out <= r_found;
            r_idx_out <= r_found ? 6'(r_ai - 1'b1) : 6'd0;
        end
    end

    assign o_valid      = r_valid;
    assign o_hit        = r_hit_out;
    assign o_area_index = r_idx_out;

`ifndef ASSERT_OFF
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_state != ST_IDLE)) else $error("busy outside a query");
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_DONE)) else $error("stray result");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result repeated");
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NEXT) |-> (r_ai <= r_limit)) else $error("area index overrun");
`endif

endmodule
